// ===== rtl/imu_sample_conditioner_unit_assert.svh =====
// Assertion macros shared by the conditioner RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef IMU_SAMPLE_CONDITIONER_UNIT_ASSERT_SVH
`define IMU_SAMPLE_CONDITIONER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMUSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMUSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/imusc_pkg.sv =====
// Shared types and constants of the IMU sample conditioner.
// Used by the interfaces, the axis lane, the heading unit and the top level.
package imusc_pkg;

	localparam int RAW_W   = 16;
	localparam int OUT_W   = 17;
	localparam int FIELD_W = 25;
	localparam int AVG_W   = 24;
	localparam int HEAD_W  = 15;
	localparam int CFG_W   = 48;
	localparam int ALPHA_W = 16;
	localparam int NUM_AXES = 3;

	// Q16 scale factors for accel and gyro counts.
	localparam logic signed [16:0] ACCEL_K = 17'sd40182;
	localparam logic signed [16:0] GYRO_K  = 17'sd32018;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd25559;

	// Register indexes of the configuration port.
	typedef logic [1:0] imusc_cfg_idx_t;
	localparam imusc_cfg_idx_t CFG_ACCEL_OFF = 2'd0;
	localparam imusc_cfg_idx_t CFG_GYRO_OFF  = 2'd1;
	localparam imusc_cfg_idx_t CFG_MAG_OFF   = 2'd2;
	localparam imusc_cfg_idx_t CFG_ALPHA     = 2'd3;

	// Heading datapath: vector in 36 bits, angle in 2^-16 degree units.
	localparam int CORDIC_XW = 36;
	localparam int CORDIC_ZW = 27;
	localparam int ATAN_LEN  = 24;
	localparam int ATAN_IW   = 5;
	localparam logic signed [CORDIC_ZW-1:0] Z_HALF     = 27'sd11796480;
	localparam logic signed [CORDIC_ZW-1:0] Z_FULL     = 27'sd23592960;
	localparam logic signed [CORDIC_ZW-1:0] Z_ROUND    = 27'sd512;
	localparam logic [16:0]                 HEAD_WRAP  = 17'd23040;
	localparam logic [HEAD_W-1:0]           HEADING_MAX = 15'd23039;

	// atan(2^-i) in units of 2^-16 degree.
	localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0
	};

	typedef struct packed {
		logic mul_en;   // register the lane products
		logic scale_en; // finish accel and gyro results
		logic filt_en;  // update the magnetometer average
		logic load;     // load the average directly from the sample
	} imusc_lane_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_START,
		ST_CORD,
		ST_LOAD
	} imusc_state_t;

endpackage

// ===== rtl/imusc_sample_if.sv =====
// Input channel of the conditioner: one raw IMU sample set per beat.
// Widths come from imusc_pkg.
interface imusc_sample_if;
	logic valid;
	logic ready;
	logic signed [imusc_pkg::RAW_W-1:0] accel_raw_x;
	logic signed [imusc_pkg::RAW_W-1:0] accel_raw_y;
	logic signed [imusc_pkg::RAW_W-1:0] accel_raw_z;
	logic signed [imusc_pkg::RAW_W-1:0] gyro_raw_x;
	logic signed [imusc_pkg::RAW_W-1:0] gyro_raw_y;
	logic signed [imusc_pkg::RAW_W-1:0] gyro_raw_z;
	logic mag_valid;
	logic signed [imusc_pkg::RAW_W-1:0] mag_raw_x;
	logic signed [imusc_pkg::RAW_W-1:0] mag_raw_y;
	logic signed [imusc_pkg::RAW_W-1:0] mag_raw_z;

	modport source (
		output valid, accel_raw_x, accel_raw_y, accel_raw_z,
		output gyro_raw_x, gyro_raw_y, gyro_raw_z,
		output mag_valid, mag_raw_x, mag_raw_y, mag_raw_z,
		input ready
	);
	modport sink (
		input valid, accel_raw_x, accel_raw_y, accel_raw_z,
		input gyro_raw_x, gyro_raw_y, gyro_raw_z,
		input mag_valid, mag_raw_x, mag_raw_y, mag_raw_z,
		output ready
	);
endinterface

// ===== rtl/imusc_result_if.sv =====
// Output channel of the conditioner: one conditioned result per beat.
// Widths come from imusc_pkg.
interface imusc_result_if;
	logic valid;
	logic ready;
	logic signed [imusc_pkg::OUT_W-1:0]   accel_x;
	logic signed [imusc_pkg::OUT_W-1:0]   accel_y;
	logic signed [imusc_pkg::OUT_W-1:0]   accel_z;
	logic signed [imusc_pkg::OUT_W-1:0]   rate_x;
	logic signed [imusc_pkg::OUT_W-1:0]   rate_y;
	logic signed [imusc_pkg::OUT_W-1:0]   rate_z;
	logic signed [imusc_pkg::FIELD_W-1:0] field_x;
	logic signed [imusc_pkg::FIELD_W-1:0] field_y;
	logic signed [imusc_pkg::FIELD_W-1:0] field_z;
	logic [imusc_pkg::HEAD_W-1:0]         heading;

	modport source (
		output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
		output field_x, field_y, field_z, heading,
		input ready
	);
	modport sink (
		input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
		input field_x, field_y, field_z, heading,
		output ready
	);
endinterface

// ===== rtl/imusc_lane.sv =====
// One axis lane: accel and gyro scaling, offset removal and the
// magnetometer low-pass filter for that axis. Depends on imusc_pkg.
module imusc_lane (
	input  logic clk,
	input  logic arst_n,
	input  imusc_pkg::imusc_lane_ctl_t ctl,
	input  logic signed [imusc_pkg::RAW_W-1:0] accel_raw,
	input  logic signed [imusc_pkg::RAW_W-1:0] gyro_raw,
	input  logic signed [imusc_pkg::RAW_W-1:0] mag_raw,
	input  logic signed [imusc_pkg::RAW_W-1:0] accel_off,
	input  logic signed [imusc_pkg::RAW_W-1:0] gyro_off,
	input  logic signed [imusc_pkg::RAW_W-1:0] mag_off,
	input  logic [imusc_pkg::ALPHA_W-1:0] alpha,
	output logic signed [imusc_pkg::OUT_W-1:0] accel,
	output logic signed [imusc_pkg::OUT_W-1:0] rate,
	output logic signed [imusc_pkg::FIELD_W-1:0] field,
	output logic avg_zero
);

	logic signed [32:0] accel_prod_s1, gyro_prod_s1;
	logic signed [41:0] filt_prod_s1;
	logic signed [imusc_pkg::AVG_W-1:0] avg_q;
	logic signed [imusc_pkg::OUT_W-1:0] accel_q, rate_q;

	logic signed [imusc_pkg::AVG_W-1:0] mag_target;
	logic signed [24:0] diff;
	logic signed [32:0] accel_sum, gyro_sum;
	logic signed [17:0] accel_d, gyro_d;
	logic signed [41:0] filt_sum;
	logic signed [26:0] avg_next;
	logic signed [imusc_pkg::AVG_W-1:0] avg_sat;

	assign mag_target = $signed({mag_raw, 8'b0});
	assign diff = $signed({mag_target[23], mag_target}) - $signed({avg_q[23], avg_q});

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			accel_prod_s1 <= accel_raw * imusc_pkg::ACCEL_K;
			gyro_prod_s1  <= gyro_raw * imusc_pkg::GYRO_K;
			filt_prod_s1  <= $signed({1'b0, alpha}) * diff;
		end
	end

	// Round half up, then a floor shift by 16.
	assign accel_sum = accel_prod_s1 + 33'sd32768;
	assign gyro_sum  = gyro_prod_s1 + 33'sd32768;
	assign accel_d = $signed({accel_sum[32], accel_sum[32:16]})
		- $signed({{2{accel_off[15]}}, accel_off});
	assign gyro_d = $signed({gyro_sum[32], gyro_sum[32:16]})
		- $signed({{2{gyro_off[15]}}, gyro_off});

	assign filt_sum = filt_prod_s1 + 42'sd32768;
	assign avg_next = $signed({{3{avg_q[23]}}, avg_q})
		+ $signed({filt_sum[41], filt_sum[41:16]});

	always_comb begin
		if (avg_next > 27'sd8388607) begin
			avg_sat = 24'sh7FFFFF;
		end else if (avg_next < -27'sd8388608) begin
			avg_sat = 24'sh800000;
		end else begin
			avg_sat = avg_next[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scale_en) begin
			accel_q <= accel_d[16:0];
			rate_q  <= gyro_d[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (ctl.filt_en) begin
			avg_q <= ctl.load ? mag_target : avg_sat;
		end
	end

	assign accel    = accel_q;
	assign rate     = rate_q;
	assign field    = $signed({avg_q[23], avg_q}) - $signed({mag_off, 8'b0});
	assign avg_zero = (avg_q == '0);

endmodule

// ===== rtl/imusc_cordic.sv =====
// Iterative vectoring CORDIC for the compass heading, one rotation per
// cycle, then the angle is folded into 1/64 degree and registered. Uses imusc_pkg.
module imusc_cordic #(
	parameter int STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [imusc_pkg::FIELD_W-1:0] fx,
	input  logic signed [imusc_pkg::FIELD_W-1:0] fy,
	output logic done,
	output logic [imusc_pkg::HEAD_W-1:0] heading
);

	localparam int IW = $clog2(STEPS);
	localparam int XW = imusc_pkg::CORDIC_XW;
	localparam int ZW = imusc_pkg::CORDIC_ZW;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0] i_q;
	logic run_q, fin_q, done_q, zero_q;
	logic [imusc_pkg::HEAD_W-1:0] heading_q;

	logic signed [XW-1:0] x0, y0, xs, ys;
	logic [imusc_pkg::ATAN_IW-1:0] tab_idx;
	logic signed [ZW-1:0] atan_step, z_wrap, z_clip, z_rnd;
	logic [16:0] h_raw, h_fold;
	logic y_pos;

	assign x0 = $signed({{3{fx[24]}}, fx, 8'b0});
	assign y0 = -$signed({{3{fy[24]}}, fy, 8'b0});

	assign tab_idx   = imusc_pkg::ATAN_IW'(i_q);
	assign atan_step = $signed({5'b0, imusc_pkg::ATAN_TAB[tab_idx]});
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign y_pos = !y_q[XW-1] && (y_q != '0);

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0[XW-1] ? -x0 : x0;
			y_q    <= x0[XW-1] ? -y0 : y0;
			z_q    <= x0[XW-1] ? imusc_pkg::Z_HALF : '0;
			zero_q <= (fx == '0) && (fy == '0);
		end else if (run_q) begin
			if (y_pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_step;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (i_q == IW'(STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				if (i_q == IW'(STEPS - 1)) begin
					run_q <= 1'b0;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	// Fold the angle into 0..360 degrees and round to 1/64 degree.
	assign z_wrap = z_q[ZW-1] ? z_q + imusc_pkg::Z_FULL : z_q;
	assign z_clip = z_wrap[ZW-1] ? '0 : z_wrap;
	assign z_rnd  = z_clip + imusc_pkg::Z_ROUND;
	assign h_raw  = z_rnd[ZW-1:10];
	assign h_fold = (h_raw >= imusc_pkg::HEAD_WRAP) ? h_raw - imusc_pkg::HEAD_WRAP : h_raw;

	always_ff @(posedge clk) begin
		if (fin_q) begin
			heading_q <= zero_q ? '0 : h_fold[imusc_pkg::HEAD_W-1:0];
		end
	end

	assign done    = done_q;
	assign heading = heading_q;

endmodule

// ===== rtl/imu_sample_conditioner_unit.sv =====
// IMU sample conditioner: three axis lanes plus a shared heading CORDIC.
// A new input beat is taken only after the previous item has been loaded
// into the output register. A result may wait in that register while the
// next beat is taken. arst_n clears the control, the filter averages and
// the offsets, and sets the filter weight to its default; the first valid
// magnetometer sample loads the averages directly.
`include "imu_sample_conditioner_unit_assert.svh"

module imu_sample_conditioner_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	imusc_sample_if.sink   sample,
	imusc_result_if.source result,
	input  logic cfg_write,
	input  imusc_pkg::imusc_cfg_idx_t cfg_index,
	input  logic [imusc_pkg::CFG_W-1:0] cfg_data
);

	localparam int NA = imusc_pkg::NUM_AXES;
	localparam int RW = imusc_pkg::RAW_W;

	// Configuration registers.
	logic [imusc_pkg::CFG_W-1:0]   accel_off_q, gyro_off_q, mag_off_q;
	logic [imusc_pkg::ALPHA_W-1:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_off_q <= '0;
			gyro_off_q  <= '0;
			mag_off_q   <= '0;
			alpha_q     <= imusc_pkg::ALPHA_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				imusc_pkg::CFG_ACCEL_OFF: accel_off_q <= cfg_data;
				imusc_pkg::CFG_GYRO_OFF:  gyro_off_q  <= cfg_data;
				imusc_pkg::CFG_MAG_OFF:   mag_off_q   <= cfg_data;
				imusc_pkg::CFG_ALPHA:     alpha_q     <= cfg_data[imusc_pkg::ALPHA_W-1:0];
			endcase
		end
	end

	// The input beat is captured once and held for the whole item, so the
	// lanes read stable raw values in every phase.
	logic signed [RW-1:0] accel_raw_q [NA];
	logic signed [RW-1:0] gyro_raw_q  [NA];
	logic signed [RW-1:0] mag_raw_q   [NA];
	logic mag_valid_q;

	logic in_accept;
	assign in_accept = sample.valid && sample.ready;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			accel_raw_q[0] <= sample.accel_raw_x;
			accel_raw_q[1] <= sample.accel_raw_y;
			accel_raw_q[2] <= sample.accel_raw_z;
			gyro_raw_q[0]  <= sample.gyro_raw_x;
			gyro_raw_q[1]  <= sample.gyro_raw_y;
			gyro_raw_q[2]  <= sample.gyro_raw_z;
			mag_raw_q[0]   <= sample.mag_raw_x;
			mag_raw_q[1]   <= sample.mag_raw_y;
			mag_raw_q[2]   <= sample.mag_raw_z;
			mag_valid_q    <= sample.mag_valid;
		end
	end

	// Sequencer.
	imusc_pkg::imusc_state_t state_q, state_d;
	imusc_pkg::imusc_lane_ctl_t lane_ctl;
	logic cordic_start, cordic_done, out_load, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imusc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imusc_pkg::ST_IDLE:  if (in_accept) state_d = imusc_pkg::ST_MUL;
			imusc_pkg::ST_MUL:   state_d = imusc_pkg::ST_UPD;
			imusc_pkg::ST_UPD:   state_d = imusc_pkg::ST_START;
			imusc_pkg::ST_START: state_d = imusc_pkg::ST_CORD;
			imusc_pkg::ST_CORD:  if (cordic_done) state_d = imusc_pkg::ST_LOAD;
			imusc_pkg::ST_LOAD:  if (!out_valid_q || result.ready) state_d = imusc_pkg::ST_IDLE;
			default:             state_d = imusc_pkg::ST_IDLE;
		endcase
	end

	// Merge of the lanes: the filter is loaded directly only when both the
	// x and y averages are zero, which no single lane can see on its own.
	logic [NA-1:0] avg_zero;

	always_comb begin
		sample.ready      = (state_q == imusc_pkg::ST_IDLE);
		lane_ctl.mul_en   = (state_q == imusc_pkg::ST_MUL);
		lane_ctl.scale_en = (state_q == imusc_pkg::ST_UPD);
		lane_ctl.filt_en  = (state_q == imusc_pkg::ST_UPD) && mag_valid_q;
		lane_ctl.load     = avg_zero[0] && avg_zero[1];
		cordic_start      = (state_q == imusc_pkg::ST_START);
		out_load          = (state_q == imusc_pkg::ST_LOAD) && (!out_valid_q || result.ready);
	end

	// Axis lanes.
	logic signed [imusc_pkg::OUT_W-1:0]   lane_accel [NA];
	logic signed [imusc_pkg::OUT_W-1:0]   lane_rate  [NA];
	logic signed [imusc_pkg::FIELD_W-1:0] lane_field [NA];

	for (genvar k = 0; k < NA; k++) begin : g_lane
		imusc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl),
			.accel_raw (accel_raw_q[k]),
			.gyro_raw  (gyro_raw_q[k]),
			.mag_raw   (mag_raw_q[k]),
			.accel_off ($signed(accel_off_q[RW*k +: RW])),
			.gyro_off  ($signed(gyro_off_q[RW*k +: RW])),
			.mag_off   ($signed(mag_off_q[RW*k +: RW])),
			.alpha     (alpha_q),
			.accel     (lane_accel[k]),
			.rate      (lane_rate[k]),
			.field     (lane_field[k]),
			.avg_zero  (avg_zero[k])
		);
	end

	// Heading from the x and y field values after the filter update.
	logic [imusc_pkg::HEAD_W-1:0] cordic_heading;

	imusc_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.fx      (lane_field[0]),
		.fy      (lane_field[1]),
		.done    (cordic_done),
		.heading (cordic_heading)
	);

	// Output register. An invalid magnetometer sample zeroes the field and
	// heading outputs; the lanes left their averages untouched.
	logic signed [imusc_pkg::OUT_W-1:0]   accel_q [NA];
	logic signed [imusc_pkg::OUT_W-1:0]   rate_q  [NA];
	logic signed [imusc_pkg::FIELD_W-1:0] field_q [NA];
	logic [imusc_pkg::HEAD_W-1:0]         heading_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int k = 0; k < NA; k++) begin
				accel_q[k] <= lane_accel[k];
				rate_q[k]  <= lane_rate[k];
				field_q[k] <= mag_valid_q ? lane_field[k] : '0;
			end
			heading_q <= mag_valid_q ? cordic_heading : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.accel_x = accel_q[0];
	assign result.accel_y = accel_q[1];
	assign result.accel_z = accel_q[2];
	assign result.rate_x  = rate_q[0];
	assign result.rate_y  = rate_q[1];
	assign result.rate_z  = rate_q[2];
	assign result.field_x = field_q[0];
	assign result.field_y = field_q[1];
	assign result.field_z = field_q[2];
	assign result.heading = heading_q;

	`IMUSC_ASSERT_NEXT(a_accept_starts_item, in_accept, state_q == imusc_pkg::ST_MUL, "accepted beat did not start an item")
	`IMUSC_ASSERT_NOW(a_done_while_waiting, cordic_done, state_q == imusc_pkg::ST_CORD, "heading finished outside the wait phase")
	`IMUSC_ASSERT_NOW(a_load_into_free_reg, out_load, !out_valid_q || result.ready, "result overwrote a pending beat")
	`IMUSC_ASSERT_NOW(a_heading_in_range, out_valid_q, heading_q <= imusc_pkg::HEADING_MAX, "heading beyond 359.98 degrees")

endmodule

// ===== tb/imu_sample_conditioner_unit_test.sv =====
// Self-checking testbench for imu_sample_conditioner_unit: scaling, offsets,
// the magnetometer low-pass filter and the CORDIC compass heading.
// Depends on imusc_pkg, imusc_sample_if and imusc_result_if from the RTL.
module imu_sample_conditioner_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAW_W    = imusc_pkg::RAW_W;
	localparam int OUT_W    = imusc_pkg::OUT_W;
	localparam int FIELD_W  = imusc_pkg::FIELD_W;
	localparam int HEAD_W   = imusc_pkg::HEAD_W;
	localparam int ALPHA_W  = imusc_pkg::ALPHA_W;
	localparam int CFG_W    = imusc_pkg::CFG_W;
	localparam int NUM_AXES = imusc_pkg::NUM_AXES;

	localparam int CORDIC_ITERS = 16;

	// Q16 gains that turn raw counts into 2^-10 m/s^2 and 2^-6 deg/s.
	localparam longint ACCEL_GAIN = 40182;
	localparam longint GYRO_GAIN  = 32018;
	localparam logic [ALPHA_W-1:0] ALPHA_DEFAULT = 16'd25559;

	// Angles are kept in units of 2^-16 degree.
	localparam longint HALF_TURN = 180 * 65536;
	localparam longint FULL_TURN = 360 * 65536;
	localparam longint HEADING_WRAP = 23040;
	localparam longint ARCTAN_STEP [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// Timing. The block takes a sample set only when the last one is through, so
	// even with one side idling more than half the time and one long output
	// stall, 2000 sample sets finish well within the cycle limit.
	localparam int SETTLE_CYCLES = CORDIC_ITERS + 14;
	localparam int OUTPUT_HOLD   = 400;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASE_ITEMS   = 330;

	localparam logic signed [RAW_W-1:0] RAW_CORNERS [5] = '{
		16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001
	};

	typedef struct {
		logic signed [RAW_W-1:0] accel [3];
		logic signed [RAW_W-1:0] gyro [3];
		logic                    mag_valid;
		logic signed [RAW_W-1:0] mag [3];
	} raw_sample_t;

	typedef struct {
		logic signed [OUT_W-1:0]   accel [3];
		logic signed [OUT_W-1:0]   rate [3];
		logic signed [FIELD_W-1:0] field [3];
		logic [HEAD_W-1:0]         heading;
	} conditioned_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	imusc_pkg::imusc_cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	imusc_sample_if smp ();
	imusc_result_if res ();

	imu_sample_conditioner_unit #(
		.CORDIC_STEPS(CORDIC_ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp),
		.result(res),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Our own copy of the register file and the filter averages. The registers
	// only change while the block is idle, so they can be read at beat time.
	logic [CFG_W-1:0]   accel_offsets = '0;
	logic [CFG_W-1:0]   gyro_offsets  = '0;
	logic [CFG_W-1:0]   mag_offsets   = '0;
	logic [ALPHA_W-1:0] filter_alpha  = ALPHA_DEFAULT;
	longint             field_avg [3] = '{0, 0, 0};

	raw_sample_t  pending_samples [$];
	conditioned_t expected_results [$];
	raw_sample_t  offered;
	bit           sample_taken;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           stall_asked;
	int           stall_given;
	int           stall_left;
	int           mismatches;
	int           cycles_run;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Registers pack three signed 16-bit lanes, x in the low bits.
	function automatic longint lane_of(logic [CFG_W-1:0] word, int k);
		logic signed [15:0] v;
		v = word[16*k +: 16];
		return longint'(v);
	endfunction

	// Vectoring CORDIC on (X, -Y) scaled up by 2^8; left half-plane vectors are
	// flipped first and start at 180 degrees. Shifts round toward minus infinity.
	function automatic logic [HEAD_W-1:0] compass_heading(longint fx, longint fy);
		longint x, y, z, nx, h;
		x = fx * 256;
		y = -fy * 256;
		z = 0;
		if (x == 0 && y == 0)
			return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN;
		end
		for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN_STEP[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN_STEP[i];
			end
			x = nx;
		end
		if (z < 0)
			z += FULL_TURN;
		if (z < 0)
			z = 0;
		h = (z + 512) >>> 10;
		if (h >= HEADING_WRAP)
			h -= HEADING_WRAP;
		return HEAD_W'(h);
	endfunction

	// Works out the result of one accepted beat and advances the filter.
	function automatic conditioned_t predict_conditioned(raw_sample_t s);
		conditioned_t r;
		longint diff, step;
		longint f [3];
		for (int k = 0; k < NUM_AXES; k++) begin
			r.accel[k] = OUT_W'(clamp(((longint'(s.accel[k]) * ACCEL_GAIN + 32768) >>> 16)
				- lane_of(accel_offsets, k), -65536, 65535));
			r.rate[k] = OUT_W'(clamp(((longint'(s.gyro[k]) * GYRO_GAIN + 32768) >>> 16)
				- lane_of(gyro_offsets, k), -65536, 65535));
			r.field[k] = '0;
		end
		r.heading = '0;
		if (!s.mag_valid)
			return r;
		// An average sitting at zero in x and y counts as unloaded.
		if (field_avg[0] == 0 && field_avg[1] == 0) begin
			for (int k = 0; k < NUM_AXES; k++)
				field_avg[k] = longint'(s.mag[k]) * 256;
		end else begin
			for (int k = 0; k < NUM_AXES; k++) begin
				diff = longint'(s.mag[k]) * 256 - field_avg[k];
				step = (longint'(filter_alpha) * diff + 32768) >>> 16;
				field_avg[k] = clamp(field_avg[k] + step, -8388608, 8388607);
			end
		end
		for (int k = 0; k < NUM_AXES; k++) begin
			f[k] = clamp(field_avg[k] - lane_of(mag_offsets, k) * 256, -16777216, 16777215);
			r.field[k] = FIELD_W'(f[k]);
		end
		r.heading = compass_heading(f[0], f[1]);
		return r;
	endfunction

	function automatic raw_sample_t make_sample(logic signed [RAW_W-1:0] a,
			logic signed [RAW_W-1:0] g, logic mv, logic signed [RAW_W-1:0] mx,
			logic signed [RAW_W-1:0] my, logic signed [RAW_W-1:0] mz);
		raw_sample_t s;
		s.accel = '{a, ~a, a};
		s.gyro = '{g, ~g, g};
		s.mag_valid = mv;
		s.mag = '{mx, my, mz};
		return s;
	endfunction

	// Mostly full-range counts, with corners and values near zero mixed in.
	function automatic logic signed [RAW_W-1:0] random_raw();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return RAW_CORNERS[$urandom_range(4)];
		if (pick < 30)
			return RAW_W'($urandom_range(64)) - 16'sd32;
		return RAW_W'($urandom);
	endfunction

	function automatic raw_sample_t random_sample();
		raw_sample_t s;
		for (int k = 0; k < NUM_AXES; k++) begin
			s.accel[k] = random_raw();
			s.gyro[k] = random_raw();
			s.mag[k] = random_raw();
		end
		s.mag_valid = $urandom_range(99) < 80;
		// A field of zero in x and y lets a fast filter decay back to the
		// unloaded state, so that the direct load is taken again later.
		if ($urandom_range(99) < 10) begin
			s.mag[0] = '0;
			s.mag[1] = '0;
		end
		return s;
	endfunction

	function automatic void check_field(string what, longint want, longint seen);
		if (want != seen) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
		end
	endfunction

	task automatic write_reg(imusc_pkg::imusc_cfg_idx_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			imusc_pkg::CFG_ACCEL_OFF: accel_offsets = value;
			imusc_pkg::CFG_GYRO_OFF:  gyro_offsets = value;
			imusc_pkg::CFG_MAG_OFF:   mag_offsets = value;
			imusc_pkg::CFG_ALPHA:     filter_alpha = value[ALPHA_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic configure(logic [CFG_W-1:0] accel_off, logic [CFG_W-1:0] gyro_off,
			logic [CFG_W-1:0] mag_off, logic [ALPHA_W-1:0] alpha);
		write_reg(imusc_pkg::CFG_ACCEL_OFF, accel_off);
		write_reg(imusc_pkg::CFG_GYRO_OFF, gyro_off);
		write_reg(imusc_pkg::CFG_MAG_OFF, mag_off);
		write_reg(imusc_pkg::CFG_ALPHA, CFG_W'(alpha));
	endtask

	task automatic queue_random(int n);
		repeat (n)
			pending_samples.push_back(random_sample());
	endtask

	// Holds off until every queued beat is taken and every result is back,
	// then lets the pipeline go quiet before returning.
	task automatic settle();
		while (pending_samples.size() != 0 || smp.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: a new beat may go out at the falling edge once the previous one
	// has been taken; valid stays up until the block accepts it.
	always @(negedge clk) begin
		if (arst_n && (!smp.valid || sample_taken)) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered = pending_samples.pop_front();
				smp.valid <= 1'b1;
				smp.accel_raw_x <= offered.accel[0];
				smp.accel_raw_y <= offered.accel[1];
				smp.accel_raw_z <= offered.accel[2];
				smp.gyro_raw_x <= offered.gyro[0];
				smp.gyro_raw_y <= offered.gyro[1];
				smp.gyro_raw_z <= offered.gyro[2];
				smp.mag_valid <= offered.mag_valid;
				smp.mag_raw_x <= offered.mag[0];
				smp.mag_raw_y <= offered.mag[1];
				smp.mag_raw_z <= offered.mag[2];
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold whenever one is asked.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else if (stall_given != stall_asked) begin
			stall_given++;
			stall_left = OUTPUT_HOLD;
			res.ready <= 1'b0;
		end else begin
			res.ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// Beats are predicted when accepted and results checked in order.
	always @(posedge clk) begin
		conditioned_t want, seen;
		sample_taken = smp.valid && smp.ready;
		if (arst_n && sample_taken)
			expected_results.push_back(predict_conditioned(offered));
		if (arst_n && res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: result beat with nothing expected, heading %0d",
					$time, res.heading);
			end else begin
				want = expected_results.pop_front();
				seen.accel = '{res.accel_x, res.accel_y, res.accel_z};
				seen.rate = '{res.rate_x, res.rate_y, res.rate_z};
				seen.field = '{res.field_x, res.field_y, res.field_z};
				seen.heading = res.heading;
				for (int k = 0; k < NUM_AXES; k++) begin
					check_field($sformatf("accel[%0d]", k), longint'(want.accel[k]),
						longint'(seen.accel[k]));
					check_field($sformatf("rate[%0d]", k), longint'(want.rate[k]),
						longint'(seen.rate[k]));
					check_field($sformatf("field[%0d]", k), longint'(want.field[k]),
						longint'(seen.field[k]));
				end
				check_field("heading", longint'(want.heading), longint'(seen.heading));
			end
		end
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run > CYCLE_LIMIT) begin
			$display("imu_sample_conditioner_unit_test failed");
			$finish;
		end
	end

	initial begin
		smp.valid = 1'b0;
		smp.accel_raw_x = '0;
		smp.accel_raw_y = '0;
		smp.accel_raw_z = '0;
		smp.gyro_raw_x = '0;
		smp.gyro_raw_y = '0;
		smp.gyro_raw_z = '0;
		smp.mag_valid = 1'b0;
		smp.mag_raw_x = '0;
		smp.mag_raw_y = '0;
		smp.mag_raw_z = '0;
		res.ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = imusc_pkg::CFG_ACCEL_OFF;
		cfg_data = '0;
		arst_n = 1'b0;
		send_idle_pct = 38;
		recv_idle_pct = 58;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed beats under the reset settings. The first zero-field beat
		// loads the filter and leaves x and y at zero, so the second beat is
		// loaded directly as well and points due south. Later beats go through
		// the filter and sweep the heading through every quadrant, while the
		// accel and gyro lanes walk their extremes.
		pending_samples.push_back(make_sample(16'sh0000, 16'sh0000, 1'b1,
			16'sh0000, 16'sh0000, 16'sh8000));
		pending_samples.push_back(make_sample(16'sh7FFF, 16'sh7FFF, 1'b1,
			16'sh8000, 16'sh0000, 16'sh7FFF));
		pending_samples.push_back(make_sample(16'sh8000, 16'sh8000, 1'b0,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		pending_samples.push_back(make_sample(16'sh0001, 16'shFFFF, 1'b1,
			16'sh7FFF, 16'sh0000, 16'sh0000));
		pending_samples.push_back(make_sample(16'shFFFF, 16'sh0001, 1'b1,
			16'sh0000, 16'sh7FFF, 16'sh0000));
		pending_samples.push_back(make_sample(16'sh4000, 16'sh0083, 1'b1,
			16'sh0000, 16'sh8000, 16'sh0000));
		pending_samples.push_back(make_sample(16'shC000, 16'shFF7D, 1'b1,
			16'sh7FFF, 16'sh7FFF, 16'shFFFF));
		pending_samples.push_back(make_sample(16'sh0000, 16'sh0000, 1'b1,
			16'sh8000, 16'sh8000, 16'sh0001));
		pending_samples.push_back(make_sample(16'sh3039, 16'shCFC7, 1'b0,
			16'shFFFF, 16'shFFFF, 16'shFFFF));
		pending_samples.push_back(make_sample(16'shFFFE, 16'sh0002, 1'b1,
			16'shFFFF, 16'sh0001, 16'sh0000));
		pending_samples.push_back(make_sample(16'sh0064, 16'shFF9C, 1'b1,
			16'sh0001, 16'shFFFF, 16'sh0000));
		pending_samples.push_back(make_sample(16'sh7FFF, 16'sh8000, 1'b1,
			16'sh0000, 16'sh0000, 16'sh0000));
		pending_samples.push_back(make_sample(16'sh8000, 16'sh7FFF, 1'b1,
			16'sh0000, 16'sh0000, 16'sh0000));
		pending_samples.push_back(make_sample(16'sh03E8, 16'sh07D0, 1'b1,
			16'sh4E20, 16'shB1E0, 16'sh0005));
		pending_samples.push_back(make_sample(16'shFC18, 16'sh0BB8, 1'b1,
			16'shB1E0, 16'sh4E20, 16'shFFFB));
		pending_samples.push_back(make_sample(16'sh5555, 16'sh2AAA, 1'b1,
			16'sh5555, 16'sh2AAA, 16'sh5555));
		pending_samples.push_back(make_sample(16'sh2AAA, 16'sh5555, 1'b0,
			16'sh0000, 16'sh0000, 16'sh0000));
		settle();

		// Most negative offsets in every lane and a frozen filter.
		configure({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 16'd0);
		queue_random(PHASE_ITEMS);
		settle();

		// Most positive offsets and the fastest filter. The output side holds
		// off for a long stretch while the sender keeps offering beats.
		configure({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 16'hFFFF);
		stall_asked++;
		queue_random(PHASE_ITEMS);
		settle();

		send_idle_pct = 58;
		recv_idle_pct = 38;
		// Random offsets with a fast filter; the sender stops halfway until
		// every result is back.
		configure(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
			CFG_W'({$urandom, $urandom}), ALPHA_W'($urandom_range(65535, 60000)));
		queue_random(PHASE_ITEMS / 2);
		settle();
		queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
		settle();

		configure(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
			CFG_W'({$urandom, $urandom}), ALPHA_W'($urandom));
		queue_random(PHASE_ITEMS);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Back to zero offsets with the slowest moving filter, then once more
		// with random settings at full rate.
		configure('0, '0, '0, 16'd1);
		queue_random(PHASE_ITEMS);
		settle();

		configure(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
			CFG_W'({$urandom, $urandom}), ALPHA_W'($urandom));
		queue_random(PHASE_ITEMS);
		settle();

		if (mismatches == 0) begin
			$display("imu_sample_conditioner_unit_test passed");
		end else begin
			$display("imu_sample_conditioner_unit_test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/imusc_pkg.sv
rtl/imusc_sample_if.sv
rtl/imusc_result_if.sv
rtl/imusc_lane.sv
rtl/imusc_cordic.sv
rtl/imu_sample_conditioner_unit.sv
tb/imu_sample_conditioner_unit_test.sv
